/* src/bps_pkg.sv */
// Shared types and constants for the blink pattern sequencer.
// No dependencies; imported by every module of the block.
package bps_pkg;

    localparam int NUM_PHASES          = 10;
    localparam int PAIR_COUNT          = 5;
    localparam int PHASE_W             = 4;
    localparam int HALF_W              = 16;
    localparam int PAIR_W              = 32;
    localparam int CFG_INDEX_W         = 3;
    localparam int DEFAULT_PERIOD_BITS = 16;

    // Command codes
    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_ON   = 2'd1;
    localparam logic [1:0] OP_OFF  = 2'd2;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_CYCLIC     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PAIR_ONE   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PAIR_TWO   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PAIR_THREE = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_PAIR_FOUR  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_PAIR_FIVE  = 3'd5;

    typedef struct packed {
        logic                               cyclic;
        logic [PAIR_COUNT-1:0][PAIR_W-1:0]  pairs;
    } cfg_t;

endpackage

/* src/bps_cfg.sv */
// Configuration register file: cyclic mode and the five phase-duration pairs.
// Depends on bps_pkg.
module bps_cfg
    import bps_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_en,
    input  logic [CFG_INDEX_W-1:0] wr_index,
    input  logic [PAIR_W-1:0]      wr_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                REG_CYCLIC:     cfg_next.cyclic   = wr_data[0];
                REG_PAIR_ONE:   cfg_next.pairs[0] = wr_data;
                REG_PAIR_TWO:   cfg_next.pairs[1] = wr_data;
                REG_PAIR_THREE: cfg_next.pairs[2] = wr_data;
                REG_PAIR_FOUR:  cfg_next.pairs[3] = wr_data;
                REG_PAIR_FIVE:  cfg_next.pairs[4] = wr_data;
                default:        cfg_next = cfg_reg;   // unlisted index: dropped
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* src/bps_core.sv */
// Next-state logic for one command: tick advance, turn-on, turn-off.
// Depends on bps_pkg; purely combinational.
module bps_core
    import bps_pkg::*;
#(
    parameter int PERIOD_BITS = DEFAULT_PERIOD_BITS
)
(
    input  cfg_t                   cfg,
    input  logic [1:0]             opcode,
    input  logic                   restart,
    input  logic                   active,
    input  logic [PHASE_W-1:0]     phase,
    input  logic [PERIOD_BITS-1:0] elapsed,
    input  logic                   level,
    output logic                   active_next,
    output logic [PHASE_W-1:0]     phase_next,
    output logic [PERIOD_BITS-1:0] elapsed_next,
    output logic                   level_next
);

    logic [PERIOD_BITS-1:0] dur [NUM_PHASES];
    logic [PHASE_W-1:0]     count;
    logic [PERIOD_BITS-1:0] dur_cur;
    logic [PERIOD_BITS-1:0] elapsed_inc;
    logic [PHASE_W-1:0]     phase_inc;
    logic [PHASE_W-1:0]     phase_on;

    // Phase durations, masked/extended to the counter width
    always_comb
    begin
        for (int i = 0; i < NUM_PHASES; i++)
        begin
            dur[i] = PERIOD_BITS'(cfg.pairs[i / 2][(i % 2) * HALF_W +: HALF_W]);
        end
    end

    // Phases in use: last nonzero among 1..9, plus one
    always_comb
    begin
        count = PHASE_W'(1);
        for (int i = 1; i < NUM_PHASES; i++)
        begin
            if (dur[i] != '0)
            begin
                count = PHASE_W'(i + 1);
            end
        end
    end

    assign dur_cur     = (phase < PHASE_W'(NUM_PHASES)) ? dur[phase] : '0;
    assign elapsed_inc = (elapsed == '1) ? elapsed : elapsed + PERIOD_BITS'(1);
    assign phase_inc   = phase + PHASE_W'(1);
    assign phase_on    = (restart || phase >= count) ? '0 : phase;

    always_comb
    begin
        active_next  = active;
        phase_next   = phase;
        elapsed_next = elapsed;
        level_next   = level;
        case (opcode)
            OP_TICK:
            begin
                if (active)
                begin
                    if (elapsed_inc >= dur_cur)
                    begin
                        elapsed_next = '0;
                        if (phase_inc >= count)
                        begin
                            phase_next  = '0;
                            active_next = cfg.cyclic;
                            level_next  = cfg.cyclic;
                        end
                        else
                        begin
                            phase_next = phase_inc;
                            level_next = ~phase_inc[0];
                        end
                    end
                    else
                    begin
                        elapsed_next = elapsed_inc;
                    end
                end
            end
            OP_ON:
            begin
                active_next  = 1'b1;
                phase_next   = phase_on;
                elapsed_next = '0;
                level_next   = ~phase_on[0];
            end
            OP_OFF:
            begin
                active_next = 1'b0;
                level_next  = 1'b0;
            end
            default:
            begin
                active_next = active;   // unused code: no change
            end
        endcase
    end

endmodule

/* src/blink_pattern_sequencer.sv */
// Top level of the blink pattern sequencer: command register, state, result register.
// Depends on bps_pkg, bps_cfg and bps_core.
//
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  in      | in_valid, in_ready, opcode, restart      | command in
//  out     | out_valid, out_ready, led_on, running,   | result out
//          | phase_index                              |
//  cfg     | cfg_valid, cfg_ready, cfg_index,cfg_data | register write
//
// One command per clock sustained while out_ready stays high. A command is held
// in the input register, is evaluated against the state registers and lands in
// the result register when the result slot is free or being emptied.
// Reset clears the state, the configuration and both valid flags.
// A stalled result holds; the input register still takes one more command
// while the result waits, then in_ready drops until out_ready returns.
// Configuration writes are taken every cycle (cfg_ready is always high).
module blink_pattern_sequencer
    import bps_pkg::*;
#(
    parameter int PERIOD_BITS = DEFAULT_PERIOD_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [1:0]             opcode,
    input  logic                   restart,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   led_on,
    output logic                   running,
    output logic [PHASE_W-1:0]     phase_index,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [PAIR_W-1:0]      cfg_data
);

    cfg_t cfg;

    // Input register
    logic                   cmd_valid_reg;
    logic                   cmd_valid_next;
    logic [1:0]             cmd_opcode_reg;
    logic                   cmd_restart_reg;

    // Pattern state
    logic                   active_reg;
    logic                   active_next;
    logic [PHASE_W-1:0]     phase_reg;
    logic [PHASE_W-1:0]     phase_next;
    logic [PERIOD_BITS-1:0] elapsed_reg;
    logic [PERIOD_BITS-1:0] elapsed_next;
    logic                   level_reg;
    logic                   level_next;

    // Result register
    logic                   res_valid_reg;
    logic                   res_valid_next;
    logic                   res_led_reg;
    logic                   res_running_reg;
    logic [PHASE_W-1:0]     res_phase_reg;

    logic                   in_take;
    logic                   advance;

    assign cfg_ready = 1'b1;

    bps_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    bps_core #(
        .PERIOD_BITS (PERIOD_BITS)
    ) u_core (
        .cfg          (cfg),
        .opcode       (cmd_opcode_reg),
        .restart      (cmd_restart_reg),
        .active       (active_reg),
        .phase        (phase_reg),
        .elapsed      (elapsed_reg),
        .level        (level_reg),
        .active_next  (active_next),
        .phase_next   (phase_next),
        .elapsed_next (elapsed_next),
        .level_next   (level_next)
    );

    // Held command moves on when the result slot is free or being emptied
    assign advance  = cmd_valid_reg && (!res_valid_reg || out_ready);
    assign in_ready = !cmd_valid_reg || advance;
    assign in_take  = in_valid && in_ready;

    always_comb
    begin
        cmd_valid_next = cmd_valid_reg;
        if (in_take)
        begin
            cmd_valid_next = 1'b1;
        end
        else if (advance)
        begin
            cmd_valid_next = 1'b0;
        end

        res_valid_next = res_valid_reg;
        if (advance)
        begin
            res_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    // Control and pattern state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
            active_reg    <= 1'b0;
            phase_reg     <= '0;
            elapsed_reg   <= '0;
            level_reg     <= 1'b0;
        end
        else
        begin
            cmd_valid_reg <= cmd_valid_next;
            res_valid_reg <= res_valid_next;
            if (advance)
            begin
                active_reg  <= active_next;
                phase_reg   <= phase_next;
                elapsed_reg <= elapsed_next;
                level_reg   <= level_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            cmd_opcode_reg  <= opcode;
            cmd_restart_reg <= restart;
        end
        if (advance)
        begin
            res_led_reg     <= level_next;
            res_running_reg <= active_next;
            res_phase_reg   <= phase_next;
        end
    end

    assign out_valid   = res_valid_reg;
    assign led_on      = res_led_reg;
    assign running     = res_running_reg;
    assign phase_index = res_phase_reg;

endmodule
